// ===== rtl/rmst_pkg.sv =====
package rmst_pkg;

    localparam int LEAVES = 1024;
    localparam int SPAN   = 1 << $clog2(LEAVES);
    localparam int NODES  = 2 * SPAN;
    localparam int IDX_W  = $clog2(NODES);
    localparam int BND_W  = IDX_W + 1;

    localparam int VAL_W = 35;
    localparam int POS_W = 10;
    localparam int RNG_W = 11;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [BND_W-1:0]        bnd_t;

    localparam value_t SENTINEL = 35'sd10000000000;

    typedef struct packed {
        logic   is_query;
        idx_t   leaf;
        value_t value;
        bnd_t   lo;
        bnd_t   hi;
    } op_t;

    function automatic value_t min_of(input value_t a, input value_t b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== rtl/rmst_if.sv =====
interface rmst_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [rmst_pkg::POS_W-1:0]  position;
    rmst_pkg::value_t            new_value;
    logic [rmst_pkg::RNG_W-1:0]  range_start;
    logic [rmst_pkg::RNG_W-1:0]  range_end;

    modport source (
        output valid, command, position, new_value, range_start, range_end,
        input  ready
    );
    modport sink (
        input  valid, command, position, new_value, range_start, range_end,
        output ready
    );
endinterface

interface rmst_rsp_if;
    logic             valid;
    logic             ready;
    rmst_pkg::value_t minimum;

    modport source (
        output valid, minimum,
        input  ready
    );
    modport sink (
        input  valid, minimum,
        output ready
    );
endinterface

// ===== rtl/rmst_ram.sv =====
module rmst_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== rtl/rmst_front.sv =====
module rmst_front (
    rmst_req_if.sink        req,
    input  logic            cleared,
    output logic            push_valid,
    input  logic            push_ready,
    output rmst_pkg::op_t   push_op
);

    logic [31:0] start_c;
    logic [31:0] end_c;
    logic        drop;

    always_comb
    begin
        start_c = (32'(req.range_start) > 32'(rmst_pkg::SPAN)) ?
                  32'(rmst_pkg::SPAN) : 32'(req.range_start);
        end_c   = (32'(req.range_end) > 32'(rmst_pkg::SPAN)) ?
                  32'(rmst_pkg::SPAN) : 32'(req.range_end);

        // Updates beyond the last leaf are taken and discarded.
        drop = (req.command == rmst_pkg::CMD_UPDATE) &&
               (32'(req.position) >= 32'(rmst_pkg::LEAVES));

        push_op.is_query = (req.command == rmst_pkg::CMD_QUERY);
        push_op.leaf     = rmst_pkg::IDX_W'(rmst_pkg::SPAN) +
                           rmst_pkg::IDX_W'(req.position);
        push_op.value    = req.new_value;
        push_op.lo       = rmst_pkg::BND_W'(start_c + 32'(rmst_pkg::SPAN));
        push_op.hi       = rmst_pkg::BND_W'(end_c + 32'(rmst_pkg::SPAN));
    end

    assign req.ready  = cleared && push_ready;
    assign push_valid = req.valid && cleared && push_ready && !drop;

endmodule

// ===== rtl/rmst_queue.sv =====
module rmst_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rmst_pkg::op_t  push_op,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rmst_pkg::op_t  pop_op
);

    rmst_pkg::op_t                 slot_reg [rmst_pkg::QDEPTH];
    logic [rmst_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [rmst_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [rmst_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [rmst_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [rmst_pkg::QCNT_W-1:0]   count_reg;
    logic [rmst_pkg::QCNT_W-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (count_reg != rmst_pkg::QCNT_W'(rmst_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == rmst_pkg::QPTR_W'(rmst_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rmst_pkg::QPTR_W'(rmst_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== rtl/rmst_back.sv =====
module rmst_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    output logic           op_ready,
    input  rmst_pkg::op_t  op,
    output logic           cleared,
    rmst_rsp_if.source     rsp
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD,
        S_QRY
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    rmst_pkg::idx_t              clr_reg;
    rmst_pkg::idx_t              clr_next;
    rmst_pkg::idx_t              node_reg;
    rmst_pkg::idx_t              node_next;
    rmst_pkg::value_t            cur_reg;
    rmst_pkg::value_t            cur_next;
    rmst_pkg::bnd_t              lo_reg;
    rmst_pkg::bnd_t              lo_next;
    rmst_pkg::bnd_t              hi_reg;
    rmst_pkg::bnd_t              hi_next;
    rmst_pkg::value_t            best_reg;
    rmst_pkg::value_t            best_next;
    logic                        pa_reg;
    logic                        pa_next;
    logic                        pb_reg;
    logic                        pb_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    rmst_pkg::value_t            out_min_reg;
    rmst_pkg::value_t            out_min_next;

    logic                        we;
    rmst_pkg::idx_t              waddr;
    rmst_pkg::value_t            wdata;
    rmst_pkg::idx_t              raddr_a;
    rmst_pkg::idx_t              raddr_b;
    logic [rmst_pkg::VAL_W-1:0]  rdata_a;
    logic [rmst_pkg::VAL_W-1:0]  rdata_b;

    rmst_pkg::idx_t              parent;
    rmst_pkg::value_t            upd_min;
    rmst_pkg::value_t            acc;
    rmst_pkg::bnd_t              hi_dec;
    logic                        out_free;

    rmst_ram #(
        .WIDTH (rmst_pkg::VAL_W),
        .DEPTH (rmst_pkg::NODES)
    ) u_nodes (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        parent   = node_reg >> 1;
        upd_min  = rmst_pkg::min_of(cur_reg, rmst_pkg::value_t'(rdata_a));
        hi_dec   = hi_reg - rmst_pkg::bnd_t'(1);
        out_free = !out_valid_reg || rsp.ready;

        // Fold in the node reads issued in the previous cycle.
        acc = best_reg;
        if (pa_reg)
        begin
            acc = rmst_pkg::min_of(acc, rmst_pkg::value_t'(rdata_a));
        end
        if (pb_reg)
        begin
            acc = rmst_pkg::min_of(acc, rmst_pkg::value_t'(rdata_b));
        end

        state_next     = state_reg;
        clr_next       = clr_reg;
        node_next      = node_reg;
        cur_next       = cur_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        best_next      = best_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_min_next   = out_min_reg;

        we       = 1'b0;
        waddr    = clr_reg;
        wdata    = rmst_pkg::SENTINEL;
        raddr_a  = lo_reg[rmst_pkg::IDX_W-1:0];
        raddr_b  = hi_dec[rmst_pkg::IDX_W-1:0];
        op_ready = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                op_ready = 1'b1;
                if (op_valid)
                begin
                    if (op.is_query)
                    begin
                        lo_next    = op.lo;
                        hi_next    = op.hi;
                        best_next  = rmst_pkg::SENTINEL;
                        pa_next    = 1'b0;
                        pb_next    = 1'b0;
                        state_next = S_QRY;
                    end
                    else
                    begin
                        we        = 1'b1;
                        waddr     = op.leaf;
                        wdata     = op.value;
                        raddr_a   = op.leaf ^ rmst_pkg::idx_t'(1);
                        node_next = op.leaf;
                        cur_next  = op.value;
                        if (op.leaf != rmst_pkg::idx_t'(1))
                        begin
                            state_next = S_UPD;
                        end
                    end
                end
            end
            S_UPD:
            begin
                we        = 1'b1;
                waddr     = parent;
                wdata     = upd_min;
                cur_next  = upd_min;
                node_next = parent;
                raddr_a   = parent ^ rmst_pkg::idx_t'(1);
                if (parent == rmst_pkg::idx_t'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_QRY:
            begin
                best_next = acc;
                if (lo_reg < hi_reg)
                begin
                    pa_next = lo_reg[0];
                    pb_next = hi_reg[0];
                    lo_next = (lo_reg + rmst_pkg::bnd_t'(lo_reg[0])) >> 1;
                    hi_next = (hi_reg - rmst_pkg::bnd_t'(hi_reg[0])) >> 1;
                end
                else
                begin
                    pa_next = 1'b0;
                    pb_next = 1'b0;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_min_next   = acc;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            node_reg      <= '0;
            cur_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            best_reg      <= '0;
            pa_reg        <= 1'b0;
            pb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_min_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            node_reg      <= node_next;
            cur_reg       <= cur_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            best_reg      <= best_next;
            pa_reg        <= pa_next;
            pb_reg        <= pb_next;
            out_valid_reg <= out_valid_next;
            out_min_reg   <= out_min_next;
        end
    end

    assign cleared     = (state_reg != S_CLEAR);
    assign rsp.valid   = out_valid_reg;
    assign rsp.minimum = out_min_reg;

endmodule

// ===== rtl/range_min_segment_tree.sv =====
// Range-minimum segment tree with point updates over 1024 leaves.
// Each beat on req carries a command: an update writes new_value at leaf
// position and gives no response; a query returns on rsp one beat whose
// minimum is the smallest value in [range_start, range_end), or 10000000000
// when that range holds no leaf.
// After reset the node memory is swept to the sentinel, one node per cycle,
// over all 2048 nodes; req.ready stays low until the sweep is done.
// Accepted beats enter a two-entry queue, so req keeps flowing while the
// tree engine works on an earlier command or a response waits on rsp.
// An update runs in the engine as a leaf write, then one step per level,
// each reading the sibling and writing the parent in the same cycle.
// A query walks one tree level per step, with both range edges
// read through the two read ports of the node memory in the same cycle.
// Accepted commands pass through the registered queue slots before work starts.
// Responses come back in command order. While rsp is stalled, the finished
// result holds in the output register and further updates keep running; a
// second query waits in the engine until the output register is taken.
module range_min_segment_tree (
    input  logic        clk,
    input  logic        rst_n,
    rmst_req_if.sink    req,
    rmst_rsp_if.source  rsp
);

    logic           cleared;
    logic           push_valid;
    logic           push_ready;
    rmst_pkg::op_t  push_op;
    logic           pop_valid;
    logic           pop_ready;
    rmst_pkg::op_t  pop_op;

    rmst_front u_front (
        .req        (req),
        .cleared    (cleared),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    rmst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    rmst_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (pop_valid),
        .op_ready (pop_ready),
        .op       (pop_op),
        .cleared  (cleared),
        .rsp      (rsp)
    );

endmodule
